[src/cbts_pkg.sv]
package cbts_pkg;

	// field widths
	localparam int CLK_W  = 30;
	localparam int CODE_W = 4;
	localparam int SP_W   = 10;
	localparam int RATE_W = 23;
	localparam int TQ_W   = 10;
	localparam int PRE_W  = 11;
	localparam int S1_W   = 8;
	localparam int S2_W   = 7;
	localparam int OPRE_W = 10;
	localparam int DIV_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CLK_W-1:0]  CLOCK_LIMIT_HZ = 30'd1000000000;
	localparam logic [CODE_W-1:0] CODE_MAX       = 4'd7;
	localparam logic [CODE_W-1:0] CODE_FAST      = 4'd5;
	localparam logic [SP_W-1:0]   SP_LOW_RESET   = 10'd800;
	localparam logic [SP_W-1:0]   SP_HIGH_RESET  = 10'd750;
	localparam logic [DIV_W-1:0]  ROUND_HALF     = 32'd500;
	localparam logic [DIV_W:0]    PERMIL         = 33'd1000;

	// divide by 1000 as multiply by ceil(2^30 / 1000) and shift; exact below 2^20
	localparam int                SPX_W          = 20;
	localparam int                PERMIL_SHIFT   = 30;
	localparam logic [20:0]       PERMIL_RECIP   = 21'd1073742;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CLOCK = 2'd1,
		ST_BAD_RATE  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SP_LOW  = 2'd0,
		CFG_SP_HIGH = 2'd1
	} cfg_idx_t;

	// one queued job: precheck status plus search operands
	typedef struct packed {
		status_t            status;
		logic [CLK_W-1:0]   clk_hz;
		logic [RATE_W-1:0]  rate;
		logic [SP_W-1:0]    sp;
	} job_t;

	function automatic logic [RATE_W-1:0] rate_hz(input logic [2:0] code);
		logic [RATE_W-1:0] r;
		case (code)
			3'd0:    r = 23'd40000;
			3'd1:    r = 23'd125000;
			3'd2:    r = 23'd250000;
			3'd3:    r = 23'd500000;
			3'd4:    r = 23'd1000000;
			3'd5:    r = 23'd2000000;
			3'd6:    r = 23'd4000000;
			default: r = 23'd8000000;
		endcase
		return r;
	endfunction

endpackage

[src/can_bit_timing_search_unit.sv]
// Flow: a word with a bad clock or rate code skips the search and goes from the queue to the
//   output register; a search runs one division for each quanta count, and a second pair of
//   divisions for each count that passes the prescaler and segment checks (32-step dividers),
//   over the default range of 382 counts.
// Throughput: one word per search; a two-entry queue takes new words while a search runs, until it is full.
// Reset: arst_n clears control, queue and output valid; sample points reset to 800 and 750.
module can_bit_timing_search_unit import cbts_pkg::*; #(
	parameter int MIN_QUANTA   = 4,
	parameter int MAX_QUANTA   = 385,
	parameter int MAX_PRESCALE = 512,
	parameter int MAX_SEG_ONE  = 255,
	parameter int MAX_SEG_TWO  = 127
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SP_W-1:0]        cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // kernel_clock_hz[29:0], rate_code[33:30]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // status[1:0], prescaler[11:2],
	                                          // phase_seg1[19:12], phase_seg2[26:20]
);

	logic q_full, q_push, q_pop, q_valid;
	job_t push_job, pop_job;

	cbts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_clk_hz(s_tdata[CLK_W-1:0]), .in_code(s_tdata[CLK_W+CODE_W-1:CLK_W]),
		.q_full(q_full), .q_push(q_push), .q_job(push_job)
	);

	cbts_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_job(push_job), .full(q_full),
		.pop(q_pop), .valid(q_valid), .pop_job(pop_job)
	);

	cbts_back #(
		.MIN_QUANTA(MIN_QUANTA), .MAX_QUANTA(MAX_QUANTA), .MAX_PRESCALE(MAX_PRESCALE),
		.MAX_SEG_ONE(MAX_SEG_ONE), .MAX_SEG_TWO(MAX_SEG_TWO)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_job(pop_job), .q_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
	);

endmodule

[src/cbts_front.sv]
module cbts_front import cbts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SP_W-1:0]       cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CLK_W-1:0]      in_clk_hz,
	input  logic [CODE_W-1:0]     in_code,
	input  logic                  q_full,
	output logic                  q_push,
	output job_t                  q_job
);

	logic [SP_W-1:0] sp_low_q;
	logic [SP_W-1:0] sp_high_q;

	// sample point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_low_q  <= SP_LOW_RESET;
			sp_high_q <= SP_HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SP_LOW:  sp_low_q  <= cfg_data;
				CFG_SP_HIGH: sp_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// classify the word
	always_comb begin
		q_job.clk_hz = in_clk_hz;
		q_job.rate   = rate_hz(in_code[2:0]);
		q_job.sp     = (in_code >= CODE_FAST) ? sp_high_q : sp_low_q;
		if (in_clk_hz == '0 || in_clk_hz > CLOCK_LIMIT_HZ)
			q_job.status = ST_BAD_CLOCK;
		else if (in_code > CODE_MAX)
			q_job.status = ST_BAD_RATE;
		else
			q_job.status = ST_OK;
	end

endmodule

[src/cbts_queue.sv]
module cbts_queue import cbts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[src/cbts_div.sv]
module cbts_div import cbts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W:0]   divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   rem_q;
	logic [DIV_W:0]   divisor_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W+1:0] shifted;
	logic             ge;

	// one restoring step
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge      = (shifted >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			rem_q     <= '0;
			divisor_q <= '0;
			quo_q     <= '0;
		end else if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
			cnt_q     <= CNT_W'(DIV_W);
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= ge ? (DIV_W+1)'(shifted - {1'b0, divisor_q}) : shifted[DIV_W:0];
			quo_q  <= {quo_q[DIV_W-2:0], ge};
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[src/cbts_back.sv]
module cbts_back import cbts_pkg::*; #(
	parameter int MIN_QUANTA   = 4,
	parameter int MAX_QUANTA   = 385,
	parameter int MAX_PRESCALE = 512,
	parameter int MAX_SEG_ONE  = 255,
	parameter int MAX_SEG_TWO  = 127
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  job_t                   q_job,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_START1, S_WAIT1, S_CHK, S_MUL2, S_WAIT2, S_CMP, S_NEXT, S_OUT
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [TQ_W-1:0]   tq_q;
	logic              found_q;
	logic [DIV_W-1:0]  best_rate_err_q;
	logic [SP_W:0]     best_sp_err_q;
	logic [PRE_W-1:0]  best_pre_q, cand_pre_q;
	logic [S1_W-1:0]   best_s1_q, cand_s1_q;
	logic [S2_W-1:0]   best_s2_q, cand_s2_q;
	logic [DIV_W:0]    den_q;
	logic [DIV_W-1:0]  spx_q;
	logic [DIV_W-1:0]  s1q_q;
	logic [SPX_W+20:0] spx_prod;
	logic              start_q;
	logic              start_b_q;
	logic [DIV_W-1:0]  a_dividend_q, b_dividend_q;
	logic [DIV_W:0]    a_divisor_q, b_divisor_q;
	logic [DIV_W-1:0]  a_quo, b_quo;
	logic              a_done, b_done;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// candidate checks on the first division
	logic [DIV_W-1:0]  s1m, s2w;
	logic              cand_ok;
	// scoring on the second pair
	logic [DIV_W-1:0]  rate_err;
	logic [SP_W:0]     sp_act, sp_err;
	logic              better;
	status_t           fin_status;

	cbts_div u_div_a (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.dividend(a_dividend_q), .divisor(a_divisor_q),
		.quotient(a_quo), .done(a_done)
	);

	cbts_div u_div_b (
		.clk(clk), .arst_n(arst_n), .start(start_b_q),
		.dividend(b_dividend_q), .divisor(b_divisor_q),
		.quotient(b_quo), .done(b_done)
	);

	// rounded segment target / 1000; sp * tq + 500 stays below 2^20
	assign spx_prod = spx_q[SPX_W-1:0] * PERMIL_RECIP;

	always_comb begin
		s1m = s1q_q - DIV_W'(1);
		s2w = DIV_W'(tq_q) - DIV_W'(1) - s1m;
		cand_ok = (a_quo != '0) && (a_quo <= DIV_W'(MAX_PRESCALE))
			&& (s1q_q != '0) && (s1m >= DIV_W'(1)) && (s1m <= DIV_W'(MAX_SEG_ONE))
			&& (s1m < DIV_W'(tq_q)) && (s2w >= DIV_W'(1))
			&& (s2w <= DIV_W'(MAX_SEG_TWO));
	end

	always_comb begin
		sp_act   = b_quo[SP_W:0];
		rate_err = (a_quo >= DIV_W'(job_q.rate)) ? a_quo - DIV_W'(job_q.rate)
			: DIV_W'(job_q.rate) - a_quo;
		sp_err   = (sp_act >= {1'b0, job_q.sp}) ? sp_act - {1'b0, job_q.sp}
			: {1'b0, job_q.sp} - sp_act;
		better   = !found_q || (rate_err < best_rate_err_q)
			|| (rate_err == best_rate_err_q && sp_err < best_sp_err_q);
	end

	always_comb begin
		if (job_q.status != ST_OK)
			fin_status = job_q.status;
		else if (found_q)
			fin_status = ST_OK;
		else
			fin_status = ST_NOT_FOUND;
	end

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			job_q           <= '0;
			tq_q            <= '0;
			found_q         <= 1'b0;
			best_rate_err_q <= '0;
			best_sp_err_q   <= '0;
			best_pre_q      <= '0;
			best_s1_q       <= '0;
			best_s2_q       <= '0;
			cand_pre_q      <= '0;
			cand_s1_q       <= '0;
			cand_s2_q       <= '0;
			den_q           <= '0;
			spx_q           <= '0;
			s1q_q           <= '0;
			start_q         <= 1'b0;
			start_b_q       <= 1'b0;
			a_dividend_q    <= '0;
			b_dividend_q    <= '0;
			a_divisor_q     <= '0;
			b_divisor_q     <= '0;
			out_valid_q     <= 1'b0;
			out_data_q      <= '0;
		end else begin
			start_q   <= 1'b0;
			start_b_q <= 1'b0;
			if (out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						job_q   <= q_job;
						tq_q    <= TQ_W'(MIN_QUANTA);
						found_q <= 1'b0;
						state_q <= (q_job.status == ST_OK) ? S_MUL1 : S_OUT;
					end
				end
				S_MUL1: begin
					den_q   <= (DIV_W+1)'(job_q.rate) * (DIV_W+1)'(tq_q);
					spx_q   <= DIV_W'(job_q.sp) * DIV_W'(tq_q) + ROUND_HALF;
					state_q <= S_START1;
				end
				S_START1: begin
					a_dividend_q <= DIV_W'(job_q.clk_hz) + den_q[DIV_W:1];
					a_divisor_q  <= den_q;
					s1q_q        <= DIV_W'(spx_prod[SPX_W+20:PERMIL_SHIFT]);
					start_q      <= 1'b1;
					state_q      <= S_WAIT1;
				end
				S_WAIT1: begin
					if (a_done)
						state_q <= S_CHK;
				end
				S_CHK: begin
					cand_pre_q <= PRE_W'(a_quo);
					cand_s1_q  <= S1_W'(s1m);
					cand_s2_q  <= S2_W'(s2w);
					state_q    <= cand_ok ? S_MUL2 : S_NEXT;
				end
				S_MUL2: begin
					a_dividend_q <= DIV_W'(job_q.clk_hz);
					a_divisor_q  <= (DIV_W+1)'(cand_pre_q) * (DIV_W+1)'(tq_q);
					b_dividend_q <= (DIV_W'(cand_s1_q) + DIV_W'(1)) * PERMIL[DIV_W-1:0];
					b_divisor_q  <= (DIV_W+1)'(tq_q);
					start_q      <= 1'b1;
					start_b_q    <= 1'b1;
					state_q      <= S_WAIT2;
				end
				S_WAIT2: begin
					if (a_done && b_done)
						state_q <= S_CMP;
				end
				S_CMP: begin
					if (a_quo != '0 && better) begin
						found_q         <= 1'b1;
						best_rate_err_q <= rate_err;
						best_sp_err_q   <= sp_err;
						best_pre_q      <= cand_pre_q;
						best_s1_q       <= cand_s1_q;
						best_s2_q       <= cand_s2_q;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (tq_q == TQ_W'(MAX_QUANTA))
						state_q <= S_OUT;
					else begin
						tq_q    <= tq_q + TQ_W'(1);
						state_q <= S_MUL1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (fin_status == ST_OK)
							out_data_q <= {5'd0, best_s2_q, best_s1_q,
								best_pre_q[OPRE_W-1:0], fin_status};
						else
							out_data_q <= {30'd0, fin_status};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/cbts_checker.sv]
module cbts_checker import cbts_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// failed status carries zero settings
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[OUT_TDATA_W-1:2] == '0)
		else $error("nonzero settings with failed status");

	// ok status carries nonzero segments and prescaler
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_OK |->
			m_tdata[19:12] != '0 && m_tdata[26:20] != '0 && m_tdata[11:2] != '0)
		else $error("ok result with empty setting");

endmodule

bind can_bit_timing_search_unit cbts_checker u_cbts_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import cbts_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [9:0] prescaler;
		logic [7:0] seg1;
		logic [6:0] seg2;
	} timing_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [SP_W-1:0]        cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// local copy of the sample point registers
	logic [SP_W-1:0] sp_low_q;
	logic [SP_W-1:0] sp_high_q;

	timing_t     timing_expected[$];
	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned searches_sent;
	longint unsigned cycle_count;
	bit          quiet;
	int unsigned out_stall;

	localparam longint unsigned CYCLE_LIMIT = 64'd30000000;

	can_bit_timing_search_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// timing search predictor
	function automatic timing_t search_timing(logic [29:0] clk_hz, logic [3:0] code);
		longint unsigned rates[8];
		longint unsigned c, rate, sp, tq, den, pre, act, s1, s2, spa, re, se, bre, bse;
		bit found;
		timing_t r;
		rates = '{40000, 125000, 250000, 500000, 1000000, 2000000, 4000000, 8000000};
		c = clk_hz;
		r = '0;
		found = 0;
		bre = 0;
		bse = 0;
		if (c == 0 || c > 1000000000) begin
			r.status = ST_BAD_CLOCK;
		end else if (code > 7) begin
			r.status = ST_BAD_RATE;
		end else begin
			rate = rates[code[2:0]];
			sp = (code >= 5) ? sp_high_q : sp_low_q;
			for (tq = 4; tq <= 385; tq++) begin
				den = rate * tq;
				pre = (c + den / 2) / den;
				if (pre == 0 || pre > 512) continue;
				act = c / (pre * tq);
				if (act == 0) continue;
				s1 = (sp * tq + 500) / 1000;
				if (s1 == 0) continue;
				s1--;
				if (s1 < 1 || s1 > 255 || s1 >= tq) continue;
				s2 = tq - 1 - s1;
				if (s2 < 1 || s2 > 127) continue;
				spa = ((1 + s1) * 1000) / tq;
				re = (act >= rate) ? act - rate : rate - act;
				se = (spa >= sp) ? spa - sp : sp - spa;
				if (!found || re < bre || (re == bre && se < bse)) begin
					found = 1;
					bre = re;
					bse = se;
					r.prescaler = pre[9:0];
					r.seg1 = s1[7:0];
					r.seg2 = s2[6:0];
				end
			end
			r.status = found ? ST_OK : ST_NOT_FOUND;
		end
		if (r.status != ST_OK) begin
			r.prescaler = '0;
			r.seg1 = '0;
			r.seg2 = '0;
		end
		return r;
	endfunction

	// result side: random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall <= 0;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (out_stall != 0) begin
			out_stall <= out_stall - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= $urandom_range(1, 11) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result word with the oldest expected one
	always @(posedge clk) begin
		timing_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tdata[1:0]);
			got.prescaler = m_tdata[11:2];
			got.seg1 = m_tdata[19:12];
			got.seg2 = m_tdata[26:20];
			if (timing_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				want = timing_expected.pop_front();
				words_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected st=%0d pre=%0d s1=%0d s2=%0d, got st=%0d pre=%0d s1=%0d s2=%0d",
							want.status, want.prescaler, want.seg1, want.seg2,
							got.status, got.prescaler, got.seg1, got.seg2);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[can_bit_timing_search_unit] ERROR");
			$finish;
		end
	end

	task automatic send_word(logic [29:0] clk_hz, logic [3:0] code);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		timing_expected.push_back(search_timing(clk_hz, code));
		if (clk_hz != 0 && clk_hz <= 1000000000 && code <= 7) searches_sent++;
		words_sent++;
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, code, clk_hz};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every expected word
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (timing_expected.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SP_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SP_LOW) sp_low_q = val;
		else if (idx == CFG_SP_HIGH) sp_high_q = val;
		@(posedge clk);
	endtask

	function automatic logic [29:0] typical_clock();
		logic [29:0] c;
		case ($urandom_range(0, 3))
			0: c = 30'(30'd8000000 * $urandom_range(1, 20));
			1: c = 30'(30'd1000000 * $urandom_range(1, 200));
			2: c = 30'($urandom_range(1000000, 1000000000));
			default: c = 30'($urandom_range(1, 2000000));
		endcase
		return c;
	endfunction

	// bad clocks and rate codes, checked ahead of any search
	task automatic test_rejects();
		send_word(30'd0, 4'd3);
		send_word(30'd1000000001, 4'd0);
		send_word(30'h3FFFFFFF, 4'd15);
		send_word(30'd0, 4'd9);
		send_word(30'd80000000, 4'd8);
		send_word(30'd80000000, 4'd15);
		drain();
	endtask

	// every rate at common clocks and the clock extremes, reset sample points
	task automatic test_rates();
		for (int k = 0; k < 8; k++) send_word(30'd80000000, k[3:0]);
		send_word(30'd1000000000, 4'd7);
		send_word(30'd1, 4'd0);
		send_word(30'd40000000, 4'd4);
		send_word(30'd160000000, 4'd1);
		drain();
	endtask

	// sample point extremes, including zero and values above 999
	task automatic test_sample_points();
		logic [SP_W-1:0] vals[5];
		vals = '{10'd1, 10'd999, 10'd0, 10'd1023, 10'd500};
		foreach (vals[i]) begin
			write_reg(CFG_SP_LOW, vals[i]);
			write_reg(CFG_SP_HIGH, vals[4 - i]);
			write_reg(2'd2, 10'd123);
			write_reg(2'd3, 10'd456);
			send_word(30'd80000000, 4'd2);
			send_word(30'd80000000, 4'd6);
			drain();
		end
	endtask

	// random words, mostly valid searches, in a few register settings
	task automatic test_random();
		logic [29:0] c;
		logic [3:0] code;
		for (int n = 0; n < 100; n++) begin
			if (n % 25 == 0) begin
				drain();
				write_reg(CFG_SP_LOW, (n == 0) ? 10'd800 : 10'($urandom_range(1, 999)));
				write_reg(CFG_SP_HIGH, (n == 0) ? 10'd750 : 10'($urandom_range(1, 999)));
			end
			if (n == 80) begin
				drain();
				quiet = 1;
			end
			if ($urandom_range(0, 4) == 0) begin
				c = 30'($urandom);
				code = 4'($urandom);
			end else begin
				c = typical_clock();
				code = 4'($urandom_range(0, 7));
			end
			send_word(c, code);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		quiet = 0;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		searches_sent = 0;
		cycle_count = 0;
		sp_low_q = 10'd800;
		sp_high_q = 10'd750;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rates();
		test_rejects();
		test_sample_points();
		test_random();

		$display("sent %0d words (%0d full searches), checked %0d results", words_sent,
			searches_sent, words_checked);
		$display("covered bad clock, bad rate, all rates and sample point extremes");
		if (mismatches == 0 && timing_expected.size() == 0) begin
			$display("[can_bit_timing_search_unit] OK");
		end else begin
			$display("[can_bit_timing_search_unit] ERROR");
		end
		$finish;
	end

endmodule
